// ----- hw/rtl/pdlc_pkg.sv -----
`timescale 1ns / 1ps

package pdlc_pkg;

    // Field widths
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned IN_CHARS  = 6;
    localparam int unsigned CODE_W    = CHAR_W * IN_CHARS;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned DOOR_W    = 2;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned MOTOR_W   = 2;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned MISS_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned OUT_PAD_W =
        OUT_W - (PHASE_W + DOOR_W + VERDICT_W + MOTOR_W + 1);

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [DOOR_W-1:0]    t_door;
    typedef logic [VERDICT_W-1:0] t_verdict;
    typedef logic [MOTOR_W-1:0]   t_motor;
    typedef logic [TICK_W-1:0]    t_tick;
    typedef logic [MISS_W-1:0]    t_miss;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Event kinds
    localparam t_mode MODE_TICK   = 2'd0;
    localparam t_mode MODE_CODE   = 2'd1;
    localparam t_mode MODE_OPEN   = 2'd2;
    localparam t_mode MODE_CHANGE = 2'd3;

    // System phases
    localparam t_phase PH_SET        = 3'd0;
    localparam t_phase PH_MENU       = 3'd1;
    localparam t_phase PH_CHK_OPEN   = 3'd2;
    localparam t_phase PH_CHK_CHANGE = 3'd3;
    localparam t_phase PH_DOOR       = 3'd4;
    localparam t_phase PH_LOCKOUT    = 3'd5;

    // Door phases
    localparam t_door DR_CLOSED    = 2'd0;
    localparam t_door DR_UNLOCKING = 2'd1;
    localparam t_door DR_OPENED    = 2'd2;
    localparam t_door DR_LOCKING   = 2'd3;

    localparam t_verdict VD_NONE    = 2'd0;
    localparam t_verdict VD_WRONG   = 2'd1;
    localparam t_verdict VD_CORRECT = 2'd2;

    localparam t_motor MOT_STOP = 2'd0;
    localparam t_motor MOT_CW   = 2'd1;
    localparam t_motor MOT_CCW  = 2'd2;

    // Register indexes
    localparam t_cfg_idx REG_OPEN_AT   = 3'd0;
    localparam t_cfg_idx REG_RELOCK_AT = 3'd1;
    localparam t_cfg_idx REG_CLOSED_AT = 3'd2;
    localparam t_cfg_idx REG_LOCKOUT   = 3'd3;
    localparam t_cfg_idx REG_MAX_FAIL  = 3'd4;

    // Register reset values
    localparam t_tick RST_OPEN_AT   = 8'd15;
    localparam t_tick RST_RELOCK_AT = 8'd18;
    localparam t_tick RST_CLOSED_AT = 8'd33;
    localparam t_tick RST_LOCKOUT   = 8'd60;
    localparam t_miss RST_MAX_FAIL  = 2'd3;

endpackage

// ----- hw/rtl/password_door_lock_controller_unit.sv -----
`timescale 1ns / 1ps

// Keypad door lock controller with lockout. Each input item is one event
// (timer tick, six-character password entry, or a menu choice of open door
// or change password) and gives exactly one status item showing the state
// after that event. Throughput is one item per clock while the master side
// accepts; items pass the input register, then the output register. A
// stalled master side holds the output register, then the input register,
// and only then drops s_axis_tready. The rate is set by the combinational
// update of the phase, door, miss and tick registers between the input and
// output registers. The first password after reset is stored; later entries
// in a check phase are compared over CODE_CHARS characters (characters
// above the six carried on the bus count as zero). After max_failures
// consecutive misses the buzzer lockout runs for lockout_ticks ticks.
// Configuration registers are written through the plain write port; the
// user must write them while the block is idle, which is not enforced.
module password_door_lock_controller_unit #(
    parameter int unsigned CODE_CHARS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Configuration write port
    input  logic                         i_cfg_we,
    input  pdlc_pkg::t_cfg_idx           i_cfg_addr,
    input  logic [pdlc_pkg::CFG_W-1:0]   i_cfg_wdata,

    // Event input
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pdlc_pkg::CODE_W-1:0]  s_axis_tdata,   // [47:0] entered_code
    input  pdlc_pkg::t_mode              s_axis_tuser,   // [1:0] mode

    // Status output
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] system_phase, [4:3] door_phase, [6:5] verdict,
    // [8:7] motor_drive, [9] buzzer, [15:10] zero
    output logic [pdlc_pkg::OUT_W-1:0]   m_axis_tdata
);

    // Only characters that exist on the bus can differ; the rest are zero
    // on both sides, so only those are stored and compared.
    localparam int unsigned STORE_CHARS =
        (CODE_CHARS < pdlc_pkg::IN_CHARS) ? CODE_CHARS : pdlc_pkg::IN_CHARS;
    localparam int unsigned STORE_W = pdlc_pkg::CHAR_W * STORE_CHARS;

    // Configuration registers
    pdlc_pkg::t_tick r_open_at;
    pdlc_pkg::t_tick r_relock_at;
    pdlc_pkg::t_tick r_closed_at;
    pdlc_pkg::t_tick r_lockout;
    pdlc_pkg::t_miss r_max_fail;

    // Input register
    logic                        r_in_vld;
    pdlc_pkg::t_mode             r_in_mode;
    logic [pdlc_pkg::CODE_W-1:0] r_in_code;

    // Controller state
    pdlc_pkg::t_phase            r_phase, n_phase;
    pdlc_pkg::t_door             r_door, n_door;
    pdlc_pkg::t_miss             r_miss, n_miss;
    pdlc_pkg::t_tick             r_tick, n_tick;
    logic [STORE_W-1:0]          r_stored;
    logic                        n_store_we;

    // Output register
    logic                        r_out_vld;
    logic [pdlc_pkg::OUT_W-1:0]  r_out_data;

    pdlc_pkg::t_verdict          w_verdict;
    pdlc_pkg::t_motor            w_motor;
    pdlc_pkg::t_tick             w_tick_inc;
    pdlc_pkg::t_miss             w_miss_inc;
    logic                        w_match;
    logic                        w_adv;

    // Item moves from the input register to the output register when the
    // output register is empty or being emptied this cycle.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_at   <= pdlc_pkg::RST_OPEN_AT;
            r_relock_at <= pdlc_pkg::RST_RELOCK_AT;
            r_closed_at <= pdlc_pkg::RST_CLOSED_AT;
            r_lockout   <= pdlc_pkg::RST_LOCKOUT;
            r_max_fail  <= pdlc_pkg::RST_MAX_FAIL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pdlc_pkg::REG_OPEN_AT:   r_open_at   <= i_cfg_wdata;
                pdlc_pkg::REG_RELOCK_AT: r_relock_at <= i_cfg_wdata;
                pdlc_pkg::REG_CLOSED_AT: r_closed_at <= i_cfg_wdata;
                pdlc_pkg::REG_LOCKOUT:   r_lockout   <= i_cfg_wdata;
                pdlc_pkg::REG_MAX_FAIL:  r_max_fail  <= i_cfg_wdata[pdlc_pkg::MISS_W-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= s_axis_tuser;
            r_in_code <= s_axis_tdata;
        end
    end

    // ---------------- event handling ----------------
    assign w_tick_inc = r_tick + pdlc_pkg::t_tick'(1);   // wraps modulo 256
    assign w_miss_inc = r_miss + pdlc_pkg::t_miss'(1);   // wraps modulo 4
    assign w_match    = (r_in_code[STORE_W-1:0] == r_stored);

    always_comb begin
        n_phase    = r_phase;
        n_door     = r_door;
        n_miss     = r_miss;
        n_tick     = r_tick;
        n_store_we = 1'b0;
        w_verdict  = pdlc_pkg::VD_NONE;

        unique case (r_in_mode)
            pdlc_pkg::MODE_TICK: begin
                if (r_phase == pdlc_pkg::PH_DOOR) begin
                    // first matching threshold wins
                    n_tick = w_tick_inc;
                    if (w_tick_inc == r_open_at) begin
                        n_door = pdlc_pkg::DR_OPENED;
                    end else if (w_tick_inc == r_relock_at) begin
                        n_door = pdlc_pkg::DR_LOCKING;
                    end else if (w_tick_inc == r_closed_at) begin
                        n_door  = pdlc_pkg::DR_CLOSED;
                        n_tick  = '0;
                        n_phase = pdlc_pkg::PH_MENU;
                    end
                end else if (r_phase == pdlc_pkg::PH_LOCKOUT) begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc == r_lockout) begin
                        n_tick  = '0;
                        n_phase = pdlc_pkg::PH_MENU;
                    end
                end
            end
            pdlc_pkg::MODE_CODE: begin
                if (r_phase == pdlc_pkg::PH_SET) begin
                    n_store_we = 1'b1;
                    n_phase    = pdlc_pkg::PH_MENU;
                end else if (r_phase == pdlc_pkg::PH_CHK_OPEN ||
                             r_phase == pdlc_pkg::PH_CHK_CHANGE) begin
                    if (!w_match) begin
                        // stay in the check phase for another try unless the miss limit is reached
                        w_verdict = pdlc_pkg::VD_WRONG;
                        n_miss    = w_miss_inc;
                        if (w_miss_inc == r_max_fail) begin
                            n_miss  = '0;
                            n_tick  = '0;
                            n_phase = pdlc_pkg::PH_LOCKOUT;
                        end
                    end else begin
                        w_verdict = pdlc_pkg::VD_CORRECT;
                        n_miss    = '0;
                        if (r_phase == pdlc_pkg::PH_CHK_OPEN) begin
                            n_tick  = '0;
                            n_door  = pdlc_pkg::DR_UNLOCKING;
                            n_phase = pdlc_pkg::PH_DOOR;
                        end else begin
                            n_phase = pdlc_pkg::PH_SET;
                        end
                    end
                end
            end
            pdlc_pkg::MODE_OPEN: begin
                if (r_phase == pdlc_pkg::PH_MENU) begin
                    n_phase = pdlc_pkg::PH_CHK_OPEN;
                end
            end
            pdlc_pkg::MODE_CHANGE: begin
                if (r_phase == pdlc_pkg::PH_MENU) begin
                    n_phase = pdlc_pkg::PH_CHK_CHANGE;
                end
            end
        endcase
    end

    // Motor follows the door only inside the door cycle
    always_comb begin
        w_motor = pdlc_pkg::MOT_STOP;
        if (n_phase == pdlc_pkg::PH_DOOR) begin
            if (n_door == pdlc_pkg::DR_UNLOCKING) begin
                w_motor = pdlc_pkg::MOT_CW;
            end else if (n_door == pdlc_pkg::DR_LOCKING) begin
                w_motor = pdlc_pkg::MOT_CCW;
            end
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pdlc_pkg::PH_SET;
            r_door  <= pdlc_pkg::DR_CLOSED;
            r_miss  <= '0;
            r_tick  <= '0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_door  <= n_door;
            r_miss  <= n_miss;
            r_tick  <= n_tick;
        end
    end

    // Stored password: read only after the set phase has written it
    always_ff @(posedge i_clk) begin
        if (w_adv && n_store_we) begin
            r_stored <= r_in_code[STORE_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {{pdlc_pkg::OUT_PAD_W{1'b0}},
                           (n_phase == pdlc_pkg::PH_LOCKOUT),
                           w_motor, w_verdict, n_door, n_phase};
        end
    end

`ifndef NO_ASSERTIONS
    // Door is only away from closed during the door cycle
    a_door_closed_outside_cycle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pdlc_pkg::PH_DOOR) |-> (r_door == pdlc_pkg::DR_CLOSED)
    ) else $error("door not closed outside the door cycle");

    // Tick counter is idle at zero outside the timed phases
    a_tick_idle_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pdlc_pkg::PH_DOOR && r_phase != pdlc_pkg::PH_LOCKOUT)
            |-> (r_tick == '0)
    ) else $error("tick count not cleared outside door cycle and lockout");

    // State only moves when an item is processed
    a_state_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_phase) && $stable(r_door) && $stable(r_miss)
                    && $stable(r_tick))
    ) else $error("controller state changed without an item");

    // Buzzer matches the lockout phase in every status item
    a_buzzer_lockout: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_data[9] ==
                       (r_out_data[2:0] == pdlc_pkg::PH_LOCKOUT))
    ) else $error("buzzer disagrees with system phase");

    // Motor only runs during the door cycle
    a_motor_in_cycle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data[8:7] != pdlc_pkg::MOT_STOP)
            |-> (r_out_data[2:0] == pdlc_pkg::PH_DOOR)
    ) else $error("motor driven outside the door cycle");
`endif

endmodule

// ----- tb/password_door_lock_controller_unit_test.sv -----
`timescale 1ns / 1ps

module password_door_lock_controller_unit_test;

    localparam int unsigned CODE_CHARS     = 6;
    localparam int unsigned NUM_PHASES     = 7;
    localparam int unsigned PHASE_ITEMS    = 225;   // counted items per random phase
    localparam int unsigned SETTLE_CYCLES  = 4;     // cycles waited after the last expected status item
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int unsigned MAX_REPORTS    = 100;

    localparam int unsigned CODE_W = pdlc_pkg::CODE_W;
    localparam int unsigned CFG_W  = pdlc_pkg::CFG_W;
    localparam int unsigned OUT_W  = pdlc_pkg::OUT_W;

    // Bit positions of the status fields in m_axis_tdata
    localparam int unsigned ST_DOOR_LSB    = pdlc_pkg::PHASE_W;
    localparam int unsigned ST_VERDICT_LSB = ST_DOOR_LSB + pdlc_pkg::DOOR_W;
    localparam int unsigned ST_MOTOR_LSB   = ST_VERDICT_LSB + pdlc_pkg::VERDICT_W;
    localparam int unsigned ST_BUZZER_BIT  = ST_MOTOR_LSB + pdlc_pkg::MOTOR_W;
    localparam int unsigned ST_PAD_LSB     = ST_BUZZER_BIT + 1;

    typedef struct {
        pdlc_pkg::t_phase   phase;
        pdlc_pkg::t_door    door;
        pdlc_pkg::t_verdict verdict;
        pdlc_pkg::t_motor   motor;
        logic               buzzer;
    } t_lock_status;

    // Lock predictor plus the queue of status items still to arrive
    class t_lock_scoreboard;
        pdlc_pkg::t_tick   open_at;
        pdlc_pkg::t_tick   relock_at;
        pdlc_pkg::t_tick   closed_at;
        pdlc_pkg::t_tick   lockout_len;
        pdlc_pkg::t_miss   max_fail;
        pdlc_pkg::t_phase  phase;
        pdlc_pkg::t_door   door;
        logic [CODE_W-1:0] stored;
        pdlc_pkg::t_miss   misses;
        pdlc_pkg::t_tick   ticks;
        t_lock_status      status_q[$];
        int unsigned       fails;

        function new();
            open_at     = pdlc_pkg::RST_OPEN_AT;
            relock_at   = pdlc_pkg::RST_RELOCK_AT;
            closed_at   = pdlc_pkg::RST_CLOSED_AT;
            lockout_len = pdlc_pkg::RST_LOCKOUT;
            max_fail    = pdlc_pkg::RST_MAX_FAIL;
            phase       = pdlc_pkg::PH_SET;
            door        = pdlc_pkg::DR_CLOSED;
            stored      = '0;
            misses      = '0;
            ticks       = '0;
            fails       = 0;
        endfunction

        function void set_reg(pdlc_pkg::t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                pdlc_pkg::REG_OPEN_AT:   open_at = val;
                pdlc_pkg::REG_RELOCK_AT: relock_at = val;
                pdlc_pkg::REG_CLOSED_AT: closed_at = val;
                pdlc_pkg::REG_LOCKOUT:   lockout_len = val;
                pdlc_pkg::REG_MAX_FAIL:  max_fail = val[pdlc_pkg::MISS_W-1:0];
                default: ;
            endcase
        endfunction

        // characters beyond the bus width compare as zero on both sides
        function logic [CODE_W-1:0] code_mask();
            logic [CODE_W-1:0] m;
            m = '0;
            for (int i = 0; i < CODE_CHARS && i < pdlc_pkg::IN_CHARS; i++)
                m[i*pdlc_pkg::CHAR_W +: pdlc_pkg::CHAR_W] = '1;
            return m;
        endfunction

        function void advance_tick();
            if (phase == pdlc_pkg::PH_DOOR) begin
                ticks = ticks + 1'b1;
                // first match wins
                if (ticks == open_at) begin
                    door = pdlc_pkg::DR_OPENED;
                end else if (ticks == relock_at) begin
                    door = pdlc_pkg::DR_LOCKING;
                end else if (ticks == closed_at) begin
                    door  = pdlc_pkg::DR_CLOSED;
                    ticks = '0;
                    phase = pdlc_pkg::PH_MENU;
                end
            end else if (phase == pdlc_pkg::PH_LOCKOUT) begin
                ticks = ticks + 1'b1;
                if (ticks == lockout_len) begin
                    ticks = '0;
                    phase = pdlc_pkg::PH_MENU;
                end
            end
        endfunction

        function pdlc_pkg::t_verdict enter_code(logic [CODE_W-1:0] code);
            logic [CODE_W-1:0] m;
            m = code_mask();
            if (phase == pdlc_pkg::PH_SET) begin
                stored = code;
                phase  = pdlc_pkg::PH_MENU;
                return pdlc_pkg::VD_NONE;
            end
            if (phase != pdlc_pkg::PH_CHK_OPEN && phase != pdlc_pkg::PH_CHK_CHANGE)
                return pdlc_pkg::VD_NONE;
            if ((code & m) != (stored & m)) begin
                misses = misses + 1'b1;   // wraps in two bits
                if (misses == max_fail) begin
                    misses = '0;
                    ticks  = '0;
                    phase  = pdlc_pkg::PH_LOCKOUT;
                end
                return pdlc_pkg::VD_WRONG;   // check phase kept for a retry unless lockout starts
            end
            misses = '0;
            if (phase == pdlc_pkg::PH_CHK_OPEN) begin
                ticks = '0;
                door  = pdlc_pkg::DR_UNLOCKING;
                phase = pdlc_pkg::PH_DOOR;
            end else begin
                phase = pdlc_pkg::PH_SET;
            end
            return pdlc_pkg::VD_CORRECT;
        endfunction

        // Queues the status of one accepted event; returns 1 if any state moved
        function bit note_event(pdlc_pkg::t_mode m, logic [CODE_W-1:0] code);
            pdlc_pkg::t_phase  p0;
            pdlc_pkg::t_door   d0;
            logic [CODE_W-1:0] s0;
            pdlc_pkg::t_miss   m0;
            pdlc_pkg::t_tick   k0;
            t_lock_status      st;
            p0 = phase;
            d0 = door;
            s0 = stored;
            m0 = misses;
            k0 = ticks;
            st.verdict = pdlc_pkg::VD_NONE;
            case (m)
                pdlc_pkg::MODE_TICK: advance_tick();
                pdlc_pkg::MODE_CODE: st.verdict = enter_code(code);
                default: begin
                    if (phase == pdlc_pkg::PH_MENU)
                        phase = (m == pdlc_pkg::MODE_OPEN) ? pdlc_pkg::PH_CHK_OPEN
                                                           : pdlc_pkg::PH_CHK_CHANGE;
                end
            endcase
            st.phase = phase;
            st.door  = door;
            st.motor = pdlc_pkg::MOT_STOP;
            if (phase == pdlc_pkg::PH_DOOR && door == pdlc_pkg::DR_UNLOCKING)
                st.motor = pdlc_pkg::MOT_CW;
            else if (phase == pdlc_pkg::PH_DOOR && door == pdlc_pkg::DR_LOCKING)
                st.motor = pdlc_pkg::MOT_CCW;
            st.buzzer = (phase == pdlc_pkg::PH_LOCKOUT);
            status_q.push_back(st);
            return (phase != p0) || (door != d0) || (stored != s0) ||
                   (misses != m0) || (ticks != k0);
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_status(logic [OUT_W-1:0] data);
            t_lock_status want;
            if (status_q.size() == 0) begin
                report("status item with none expected", data, 0);
                return;
            end
            want = status_q.pop_front();
            if (data[pdlc_pkg::PHASE_W-1:0] !== want.phase)
                report("system_phase", data[pdlc_pkg::PHASE_W-1:0], want.phase);
            if (data[ST_DOOR_LSB +: pdlc_pkg::DOOR_W] !== want.door)
                report("door_phase", data[ST_DOOR_LSB +: pdlc_pkg::DOOR_W], want.door);
            if (data[ST_VERDICT_LSB +: pdlc_pkg::VERDICT_W] !== want.verdict)
                report("verdict", data[ST_VERDICT_LSB +: pdlc_pkg::VERDICT_W],
                       want.verdict);
            if (data[ST_MOTOR_LSB +: pdlc_pkg::MOTOR_W] !== want.motor)
                report("motor_drive", data[ST_MOTOR_LSB +: pdlc_pkg::MOTOR_W], want.motor);
            if (data[ST_BUZZER_BIT] !== want.buzzer)
                report("buzzer", data[ST_BUZZER_BIT], want.buzzer);
            if (data[OUT_W-1:ST_PAD_LSB] !== '0)
                report("padding", data[OUT_W-1:ST_PAD_LSB], 0);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    pdlc_pkg::t_cfg_idx i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [CODE_W-1:0]  s_axis_tdata;    // [47:0] entered_code
    pdlc_pkg::t_mode    s_axis_tuser;    // [1:0] mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [2:0] system_phase, [4:3] door_phase, [6:5] verdict,
    // [8:7] motor_drive, [9] buzzer, [15:10] zero
    logic [OUT_W-1:0]   m_axis_tdata;

    t_lock_scoreboard   sb;
    bit                 no_idle = 1'b0;  // set for back-to-back phases
    int unsigned        rx_hold = 0;
    int unsigned        idle_cycles = 0;

    password_door_lock_controller_unit #(
        .CODE_CHARS(CODE_CHARS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        logic [63:0] w;
        int unsigned r;
        r = $urandom_range(0, 19);
        w = {$urandom(), $urandom()};
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return w[CODE_W-1:0];
    endfunction

    // Configuration is only written while nothing is in flight
    task automatic write_register(pdlc_pkg::t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(pdlc_pkg::t_tick open_at, pdlc_pkg::t_tick relock_at,
                              pdlc_pkg::t_tick closed_at, pdlc_pkg::t_tick lockout_len,
                              pdlc_pkg::t_miss max_fail);
        write_register(pdlc_pkg::REG_OPEN_AT, open_at);
        write_register(pdlc_pkg::REG_RELOCK_AT, relock_at);
        write_register(pdlc_pkg::REG_CLOSED_AT, closed_at);
        write_register(pdlc_pkg::REG_LOCKOUT, lockout_len);
        write_register(pdlc_pkg::REG_MAX_FAIL, CFG_W'(max_fail));
        i_cfg_we <= 1'b0;
    endtask

    // Offers one event item and waits for it to be taken.
    // The predictor is fed here, so the next choice sees the new state.
    task automatic send_event(pdlc_pkg::t_mode m, logic [CODE_W-1:0] code,
                              output bit counted);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= m;
        do
            @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        counted = sb.note_event(m, code);
    endtask

    // Mostly follows the flow of a real user, with some noise mixed in
    task automatic play_random(output bit counted);
        int unsigned       r;
        pdlc_pkg::t_mode   m;
        logic [CODE_W-1:0] code;
        r    = $urandom_range(0, 99);
        code = random_code();
        m    = pdlc_pkg::t_mode'($urandom_range(0, 3));
        if (r >= 12) begin
            case (sb.phase)
                pdlc_pkg::PH_SET:  m = pdlc_pkg::MODE_CODE;
                pdlc_pkg::PH_MENU: m = (r < 70) ? pdlc_pkg::MODE_OPEN
                                                : pdlc_pkg::MODE_CHANGE;
                pdlc_pkg::PH_CHK_OPEN, pdlc_pkg::PH_CHK_CHANGE: begin
                    m = pdlc_pkg::MODE_CODE;
                    if (r < 50)
                        code = sb.stored;
                    else if (r < 80)
                        code = sb.stored ^ (CODE_W'(1) << $urandom_range(0, CODE_W - 1));
                end
                default: m = pdlc_pkg::MODE_TICK;
            endcase
        end
        send_event(m, code, counted);
    endtask

    // Drop valid, wait for every queued status, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Status sink with random back-pressure
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            rx_hold       <= gap_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_status(m_axis_tdata);
    end

    // No handshake on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit              counted;
        int unsigned     done;
        pdlc_pkg::t_tick open_at;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= pdlc_pkg::REG_OPEN_AT;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= pdlc_pkg::MODE_TICK;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short timings so a whole door cycle and a lockout fit
        set_config(8'd2, 8'd3, 8'd4, 8'd2, 2'd2);
        send_event(pdlc_pkg::MODE_TICK, '0, counted);     // tick while setting: ignored
        send_event(pdlc_pkg::MODE_OPEN, '1, counted);     // menu choice outside menu
        send_event(pdlc_pkg::MODE_CODE, '1, counted);     // first code is stored
        send_event(pdlc_pkg::MODE_CODE, '0, counted);     // code in menu: ignored
        send_event(pdlc_pkg::MODE_TICK, '1, counted);     // tick in menu: ignored
        send_event(pdlc_pkg::MODE_CHANGE, '0, counted);
        send_event(pdlc_pkg::MODE_OPEN, '0, counted);     // choice during a check
        send_event(pdlc_pkg::MODE_CODE, '0, counted);     // wrong, retry allowed
        send_event(pdlc_pkg::MODE_CODE, '1, counted);     // correct: back to setting
        send_event(pdlc_pkg::MODE_CODE, '0, counted);     // new code all zero
        send_event(pdlc_pkg::MODE_OPEN, '1, counted);
        send_event(pdlc_pkg::MODE_CODE, '1, counted);     // wrong
        send_event(pdlc_pkg::MODE_CODE, CODE_W'(1), counted); // second miss: lockout
        send_event(pdlc_pkg::MODE_CODE, '0, counted);     // code during lockout
        send_event(pdlc_pkg::MODE_OPEN, '0, counted);     // choice during lockout
        send_event(pdlc_pkg::MODE_TICK, '0, counted);
        send_event(pdlc_pkg::MODE_TICK, '0, counted);     // lockout over
        send_event(pdlc_pkg::MODE_OPEN, '0, counted);
        send_event(pdlc_pkg::MODE_CODE, '0, counted);     // correct: unlocking
        send_event(pdlc_pkg::MODE_CODE, '1, counted);     // code during door cycle
        send_event(pdlc_pkg::MODE_CHANGE, '1, counted);   // choice during door cycle
        send_event(pdlc_pkg::MODE_TICK, '0, counted);
        send_event(pdlc_pkg::MODE_TICK, '0, counted);     // opened
        send_event(pdlc_pkg::MODE_TICK, '0, counted);     // locking
        send_event(pdlc_pkg::MODE_TICK, '0, counted);     // closed, back to menu

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: set_config(8'd1, 8'd2, 8'd3, 8'd1, 2'd1);
                1: set_config(8'd253, 8'd254, 8'd255, 8'd255, 2'd3);
                default: begin
                    open_at = pdlc_pkg::t_tick'($urandom_range(1, 12));
                    // a close time equal to the open time keeps the door cycling
                    set_config(open_at,
                               pdlc_pkg::t_tick'($urandom_range(1, 20)),
                               ($urandom_range(0, 9) == 0)
                                   ? open_at
                                   : pdlc_pkg::t_tick'($urandom_range(1, 30)),
                               pdlc_pkg::t_tick'($urandom_range(1, 20)),
                               pdlc_pkg::t_miss'($urandom_range(1, 3)));
                end
            endcase
            no_idle = (ph == 3 || ph == 5);
            done = 0;
            // only items that move the lock's state are counted
            while (done < PHASE_ITEMS) begin
                play_random(counted);
                if (counted)
                    done++;
            end
        end

        settle();
        if (sb.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pdlc_pkg.sv
hw/rtl/password_door_lock_controller_unit.sv
tb/password_door_lock_controller_unit_test.sv
